>>> sv/gglb_pkg.sv
// shared types, constants and microcode program of the grid distance bound core
package gglb_pkg;

	localparam int MAX_SIDE_DEF = 64;
	localparam int MAX_HOPS_DEF = 128;

	localparam int SIDE_CFG_W = 7;
	localparam int DEG_CFG_W  = 6;
	localparam int LEN_CFG_W  = 7;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 2;

	localparam int DIAM_W  = 8;
	localparam int SUM_W   = 32;
	localparam int PAIRS_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_DEGREE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGE_LENGTH = 2'd3;

	localparam logic [SIDE_CFG_W-1:0] GRID_WIDTH_RST      = 7'd2;
	localparam logic [SIDE_CFG_W-1:0] GRID_HEIGHT_RST     = 7'd2;
	localparam logic [DEG_CFG_W-1:0]  NODE_DEGREE_RST     = 6'd4;
	localparam logic [LEN_CFG_W-1:0]  MAX_EDGE_LENGTH_RST = 7'd1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SETUP,
		OP_NODES,
		OP_PAIRS,
		OP_HOPTAB,
		OP_MMUL,
		OP_MADD,
		OP_PAIR,
		OP_SCAN,
		OP_PART,
		OP_ACC,
		OP_LOAD
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_GO,
		C_D_MORE,
		C_K_MORE,
		C_PAIR_MORE,
		C_POINT_MORE,
		C_OUT_BUSY
	} cond_t;

	localparam int STEPS = 17;
	localparam int PC_W  = $clog2(STEPS);

	localparam logic [PC_W-1:0] P_IDLE    = PC_W'(0);
	localparam logic [PC_W-1:0] P_SETUP   = PC_W'(1);
	localparam logic [PC_W-1:0] P_NODES   = PC_W'(2);
	localparam logic [PC_W-1:0] P_PAIRS   = PC_W'(3);
	localparam logic [PC_W-1:0] P_HOPTAB  = PC_W'(4);
	localparam logic [PC_W-1:0] P_MMUL    = PC_W'(5);
	localparam logic [PC_W-1:0] P_MADD    = PC_W'(6);
	localparam logic [PC_W-1:0] P_PAIR    = PC_W'(7);
	localparam logic [PC_W-1:0] P_PDRAIN1 = PC_W'(8);
	localparam logic [PC_W-1:0] P_PDRAIN2 = PC_W'(9);
	localparam logic [PC_W-1:0] P_SCAN    = PC_W'(10);
	localparam logic [PC_W-1:0] P_SDRAIN1 = PC_W'(11);
	localparam logic [PC_W-1:0] P_SDRAIN2 = PC_W'(12);
	localparam logic [PC_W-1:0] P_PART    = PC_W'(13);
	localparam logic [PC_W-1:0] P_ACC     = PC_W'(14);
	localparam logic [PC_W-1:0] P_FINISH  = PC_W'(15);
	localparam logic [PC_W-1:0] P_DONE    = PC_W'(16);

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic d_more;
		logic k_more;
		logic pair_more;
		logic point_more;
	} gglb_flags_t;

	typedef struct packed {
		logic [SIDE_CFG_W-1:0] grid_width;
		logic [SIDE_CFG_W-1:0] grid_height;
		logic [DEG_CFG_W-1:0]  node_degree;
		logic [LEN_CFG_W-1:0]  max_edge_length;
	} gglb_cfg_t;

	typedef struct packed {
		logic [DIAM_W-1:0]  diameter_bound;
		logic [SUM_W-1:0]   path_sum;
		logic [PAIRS_W-1:0] pair_count;
	} gglb_result_t;

	// control store: jump to target when cond holds, else fall through
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NONE, cond: C_NEVER, target: P_IDLE};
		case (pc)
			P_IDLE:    w = '{op: OP_NONE,   cond: C_NO_GO,      target: P_IDLE};
			P_SETUP:   w = '{op: OP_SETUP,  cond: C_NEVER,      target: P_IDLE};
			P_NODES:   w = '{op: OP_NODES,  cond: C_NEVER,      target: P_IDLE};
			P_PAIRS:   w = '{op: OP_PAIRS,  cond: C_NEVER,      target: P_IDLE};
			P_HOPTAB:  w = '{op: OP_HOPTAB, cond: C_D_MORE,     target: P_HOPTAB};
			P_MMUL:    w = '{op: OP_MMUL,   cond: C_NEVER,      target: P_IDLE};
			P_MADD:    w = '{op: OP_MADD,   cond: C_K_MORE,     target: P_MMUL};
			P_PAIR:    w = '{op: OP_PAIR,   cond: C_PAIR_MORE,  target: P_PAIR};
			P_PDRAIN1: w = '{op: OP_NONE,   cond: C_NEVER,      target: P_IDLE};
			P_PDRAIN2: w = '{op: OP_NONE,   cond: C_NEVER,      target: P_IDLE};
			P_SCAN:    w = '{op: OP_SCAN,   cond: C_K_MORE,     target: P_SCAN};
			P_SDRAIN1: w = '{op: OP_NONE,   cond: C_NEVER,      target: P_IDLE};
			P_SDRAIN2: w = '{op: OP_NONE,   cond: C_NEVER,      target: P_IDLE};
			P_PART:    w = '{op: OP_PART,   cond: C_NEVER,      target: P_IDLE};
			P_ACC:     w = '{op: OP_ACC,    cond: C_POINT_MORE, target: P_PAIR};
			P_FINISH:  w = '{op: OP_LOAD,   cond: C_OUT_BUSY,   target: P_FINISH};
			P_DONE:    w = '{op: OP_NONE,   cond: C_ALWAYS,     target: P_IDLE};
			default:   w = '{op: OP_NONE,   cond: C_ALWAYS,     target: P_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> sv/gglb_seq.sv
// microcode sequencer: step counter, control store and jump conditions
module gglb_seq import gglb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic        out_busy,
	input  gglb_flags_t flags,
	output op_t         op,
	output logic        idle
);

	logic [PC_W-1:0] pc_q;
	ucode_t          uw;
	logic            take;

	assign uw   = ucode_rom(pc_q);
	assign op   = uw.op;
	assign idle = (pc_q == P_IDLE);

	always_comb begin
		case (uw.cond)
			C_NEVER:      take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_NO_GO:      take = !go;
			C_D_MORE:     take = flags.d_more;
			C_K_MORE:     take = flags.k_more;
			C_PAIR_MORE:  take = flags.pair_more;
			C_POINT_MORE: take = flags.point_more;
			C_OUT_BUSY:   take = out_busy;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

>>> sv/gglb_dp.sv
// datapath: hop table, moore table, hop histogram and accumulators
module gglb_dp import gglb_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int MAX_HOPS = MAX_HOPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  op_t          op,
	input  gglb_cfg_t    cfg,
	output gglb_flags_t  flags,
	output gglb_result_t res
);

	localparam int SW     = $clog2(MAX_SIDE + 1);
	localparam int CW     = $clog2(MAX_SIDE);
	localparam int NW     = 2 * SW;
	localparam int HDEPTH = MAX_HOPS + 1;
	localparam int HW     = $clog2(HDEPTH);
	localparam int DDEPTH = 2 * MAX_SIDE - 1;
	localparam int DW     = $clog2(DDEPTH);
	localparam int D_LAST = DDEPTH - 1;
	localparam int PW     = NW + HW;
	localparam int MW     = NW + DEG_CFG_W;

	// memories
	logic [HW-1:0] hop_mem   [DDEPTH];
	logic [NW-1:0] moore_mem [HDEPTH];
	logic [NW-1:0] hist_mem  [HDEPTH];

	// setup registers
	logic [SW-1:0]        w_q, h_q;
	logic [LEN_CFG_W-1:0] len_q;
	logic [DEG_CFG_W-1:0] deg_q;
	logic [NW-1:0]        nodes_q;
	logic [PAIRS_W-1:0]   pairs_q;

	// hop table build
	logic [DW-1:0]        d_q, hq_q;
	logic [LEN_CFG_W-1:0] hr_q;
	logic [HW-1:0]        hop_sat;

	// moore build
	logic [NW-1:0]        g_q, m_q, g_sat, m_new;
	logic [MW-1:0]        prod_q;
	logic [NW:0]          m_sum;
	logic [DEG_CFG_W-1:0] factor, mul_sel;

	// point and pair walk
	logic [CW-1:0] x_q, y_q, x2_q, y2_q;
	logic [CW-1:0] dx, dy;
	logic [DW-1:0] pair_d;
	logic          x_last, y_last, x2_last, y2_last;

	// histogram update pipe
	logic          pair_vld_s1, pair_vld_s2;
	logic [HW-1:0] hop_s1, hop_s2;
	logic [NW-1:0] hist_rd, moore_rd;
	logic          wr_vld_q;
	logic [HW-1:0] wr_addr_q;
	logic [NW-1:0] wr_val_q;
	logic [NW-1:0] hist_base, hist_inc;

	logic          hist_we;
	logic [HW-1:0] hist_waddr, hist_raddr;
	logic [NW-1:0] hist_wdata;

	// scan pipe
	logic [HW-1:0] k_q, k_s1, k_s2;
	logic          scan_vld_s1, scan_vld_s2;
	logic [NW-1:0] cum_q, cum_new, c_s2;
	logic [PW-1:0] csum_q, part_q;
	logic [NW-1:0] cmax_q;
	logic          found_q;
	logic [HW-1:0] diam_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   acc_sum;

	// combinational helpers
	assign hop_sat = (32'(hq_q) > 32'(MAX_HOPS)) ? HW'(MAX_HOPS) : HW'(hq_q);

	assign factor  = (deg_q == '0) ? '0 : deg_q - DEG_CFG_W'(1);
	assign mul_sel = (k_q == HW'(1)) ? DEG_CFG_W'(1) : factor;
	assign g_sat   = (prod_q > MW'(nodes_q)) ? nodes_q : NW'(prod_q);
	assign m_sum   = (NW + 1)'(m_q) + (NW + 1)'(g_sat);
	assign m_new   = (m_sum > (NW + 1)'(nodes_q)) ? nodes_q : NW'(m_sum);

	assign dx      = (x_q > x2_q) ? x_q - x2_q : x2_q - x_q;
	assign dy      = (y_q > y2_q) ? y_q - y2_q : y2_q - y_q;
	assign pair_d  = DW'(dx) + DW'(dy);

	assign x_last  = (SW'(x_q)  == w_q - SW'(1));
	assign y_last  = (SW'(y_q)  == h_q - SW'(1));
	assign x2_last = (SW'(x2_q) == w_q - SW'(1));
	assign y2_last = (SW'(y2_q) == h_q - SW'(1));

	// one-deep forward for back-to-back hits on the same bin
	assign hist_base = (wr_vld_q && wr_addr_q == hop_s2) ? wr_val_q : hist_rd;
	assign hist_inc  = hist_base + NW'(1);

	assign cum_new = cum_q + hist_rd;
	assign acc_sum = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(part_q);

	assign hist_raddr = (op == OP_SCAN) ? k_q : hop_s1;

	always_comb begin
		hist_we    = 1'b0;
		hist_waddr = k_q;
		hist_wdata = '0;
		if (pair_vld_s2) begin
			hist_we    = 1'b1;
			hist_waddr = hop_s2;
			hist_wdata = hist_inc;
		end else if (op == OP_SCAN || op == OP_MADD) begin
			hist_we    = 1'b1;
		end else if (op == OP_PAIRS) begin
			hist_we    = 1'b1;
			hist_waddr = '0;
		end
	end

	assign flags.d_more     = (d_q != DW'(D_LAST));
	assign flags.k_more     = (k_q != HW'(MAX_HOPS));
	assign flags.pair_more  = !(x2_last && y2_last);
	assign flags.point_more = !(x_last && y_last);

	assign res.diameter_bound = DIAM_W'(diam_q);
	assign res.path_sum       = sum_q;
	assign res.pair_count     = pairs_q;

	// memories
	always_ff @(posedge clk) begin
		if (op == OP_HOPTAB) begin
			hop_mem[d_q] <= hop_sat;
		end
		hop_s1 <= hop_mem[pair_d];
	end

	always_ff @(posedge clk) begin
		if (op == OP_PAIRS) begin
			moore_mem[HW'(0)] <= NW'(1);
		end else if (op == OP_MADD) begin
			moore_mem[k_q] <= m_new;
		end
		moore_rd <= moore_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd <= hist_mem[hist_raddr];
	end

	// pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_vld_s1 <= 1'b0;
			pair_vld_s2 <= 1'b0;
			wr_vld_q    <= 1'b0;
			scan_vld_s1 <= 1'b0;
			scan_vld_s2 <= 1'b0;
		end else begin
			pair_vld_s1 <= (op == OP_PAIR);
			pair_vld_s2 <= pair_vld_s1;
			wr_vld_q    <= pair_vld_s2;
			scan_vld_s1 <= (op == OP_SCAN);
			scan_vld_s2 <= scan_vld_s1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		hop_s2    <= hop_s1;
		wr_addr_q <= hop_s2;
		wr_val_q  <= hist_inc;
		k_s1      <= k_q;
		k_s2      <= k_s1;

		case (op)
			OP_SETUP: begin
				if (cfg.grid_width == '0) begin
					w_q <= SW'(1);
				end else if (32'(cfg.grid_width) > 32'(MAX_SIDE)) begin
					w_q <= SW'(MAX_SIDE);
				end else begin
					w_q <= SW'(cfg.grid_width);
				end
				if (cfg.grid_height == '0) begin
					h_q <= SW'(1);
				end else if (32'(cfg.grid_height) > 32'(MAX_SIDE)) begin
					h_q <= SW'(MAX_SIDE);
				end else begin
					h_q <= SW'(cfg.grid_height);
				end
				len_q <= (cfg.max_edge_length == '0) ? LEN_CFG_W'(1) : cfg.max_edge_length;
				deg_q <= cfg.node_degree;
				d_q   <= '0;
				hq_q  <= '0;
				hr_q  <= '0;
				x_q   <= '0;
				y_q   <= '0;
				x2_q  <= '0;
				y2_q  <= '0;
				sum_q <= '0;
			end
			OP_NODES: begin
				nodes_q <= NW'(w_q) * NW'(h_q);
			end
			OP_PAIRS: begin
				pairs_q <= PAIRS_W'((2 * NW)'(nodes_q) * (2 * NW)'(nodes_q - NW'(1)));
				g_q     <= (MW'(deg_q) > MW'(nodes_q)) ? nodes_q : NW'(deg_q);
				m_q     <= NW'(1);
				k_q     <= HW'(1);
			end
			OP_HOPTAB: begin
				d_q <= d_q + DW'(1);
				if (hr_q == '0) begin
					hq_q <= hq_q + DW'(1);
					hr_q <= len_q - LEN_CFG_W'(1);
				end else begin
					hr_q <= hr_q - LEN_CFG_W'(1);
				end
			end
			OP_MMUL: begin
				prod_q <= MW'(g_q) * MW'(mul_sel);
			end
			OP_MADD: begin
				g_q <= g_sat;
				m_q <= m_new;
				k_q <= k_q + HW'(1);
			end
			OP_PAIR: begin
				if (y2_last) begin
					y2_q <= '0;
					x2_q <= x2_last ? '0 : x2_q + CW'(1);
				end else begin
					y2_q <= y2_q + CW'(1);
				end
				k_q     <= '0;
				cum_q   <= '0;
				csum_q  <= '0;
				found_q <= 1'b0;
				diam_q  <= HW'(MAX_HOPS);
			end
			OP_SCAN: begin
				k_q <= k_q + HW'(1);
			end
			OP_PART: begin
				part_q <= PW'(cmax_q) * PW'(MAX_HOPS) - csum_q;
			end
			OP_ACC: begin
				sum_q <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
				if (y_last) begin
					y_q <= '0;
					x_q <= x_q + CW'(1);
				end else begin
					y_q <= y_q + CW'(1);
				end
			end
			default: begin
			end
		endcase

		// scan stage 1: running cumulative count clamped by the moore table
		if (scan_vld_s1) begin
			cum_q <= cum_new;
			c_s2  <= (cum_new < moore_rd) ? cum_new : moore_rd;
		end

		// scan stage 2: table sum, last entry and first full entry
		if (scan_vld_s2) begin
			if (k_s2 == HW'(MAX_HOPS)) begin
				cmax_q <= c_s2;
			end else begin
				csum_q <= csum_q + PW'(c_s2);
			end
			if (!found_q && c_s2 == nodes_q) begin
				found_q <= 1'b1;
				diam_q  <= k_s2;
			end
		end
	end

endmodule

>>> sv/grid_graph_distance_lower_bound_core.sv
// top level of the grid graph distance lower bound core
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-----------------------------------------
//  config   | cfg_write_en                    | cfg_index[1:0], cfg_data[6:0]
//  input    | in_valid / in_stall             | start_req
//  output   | out_valid / out_stall           | diameter_bound, path_sum, pair_count
//
//  an item with start_req 1 runs a full bound computation; start_req 0 is taken and dropped
//  the histogram walk takes one pair per cycle; each point then scans MAX_HOPS+1 table entries
//  reset clears the sequencer, pipe valid bits, output valid and the config registers;
//  the memories need no clearing since each table is rebuilt before it is read
//  a new item is taken only while the sequencer sits idle; a result waiting in the output
//  register does not block the next start, only the final load of the next result
module grid_graph_distance_lower_bound_core import gglb_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int MAX_HOPS = MAX_HOPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  start_req,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DIAM_W-1:0]     diameter_bound,
	output logic [SUM_W-1:0]      path_sum,
	output logic [PAIRS_W-1:0]    pair_count
);

	gglb_cfg_t    cfg_q;
	gglb_flags_t  flags;
	gglb_result_t res;
	op_t          op;
	logic         seq_idle;
	logic         go;
	logic         out_valid_q;
	logic         load;

	// only a start item launches the program
	assign in_stall = !seq_idle;
	assign go       = in_valid && seq_idle && start_req;

	// config registers, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width      <= GRID_WIDTH_RST;
			cfg_q.grid_height     <= GRID_HEIGHT_RST;
			cfg_q.node_degree     <= NODE_DEGREE_RST;
			cfg_q.max_edge_length <= MAX_EDGE_LENGTH_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_GRID_WIDTH:      cfg_q.grid_width      <= cfg_data;
				REG_GRID_HEIGHT:     cfg_q.grid_height     <= cfg_data;
				REG_NODE_DEGREE:     cfg_q.node_degree     <= cfg_data[DEG_CFG_W-1:0];
				REG_MAX_EDGE_LENGTH: cfg_q.max_edge_length <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gglb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.out_busy (out_valid_q),
		.flags    (flags),
		.op       (op),
		.idle     (seq_idle)
	);

	gglb_dp #(
		.MAX_SIDE (MAX_SIDE),
		.MAX_HOPS (MAX_HOPS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.cfg    (cfg_q),
		.flags  (flags),
		.res    (res)
	);

	// output register: the sequencer holds in its finish step until this is free
	assign load = (op == OP_LOAD) && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			diameter_bound <= res.diameter_bound;
			path_sum       <= res.path_sum;
			pair_count     <= res.pair_count;
		end
	end

	assign out_valid = out_valid_q;

endmodule
